// ===== rtl/unsigned_to_decimal_ascii_assert.svh =====
// Assertion macros for the unsigned-to-decimal ASCII converter.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante.
`define U2D_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define U2D_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define U2D_ASSERT_SAME(name, ante, cons, msg)
`define U2D_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/u2d_pkg.sv =====
// Shared types and constants for the unsigned-to-decimal ASCII converter.
// No dependencies.
package u2d_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int HW_DIGITS      = 10;  // digits in the largest 32-bit value
    localparam int MAX_DIGITS_DEF = 10;
    localparam int ASCII_ZERO     = 48;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } u2d_state_t;

    typedef struct packed {
        logic load;     // capture the value, clear the digit buffer
        logic step;     // one shift-and-add-3 step
        logic advance;  // drop the top digit, count down
    } u2d_cmd_t;

    typedef struct packed {
        logic conv_done;  // this is the last conversion step
        logic top_zero;   // top buffered digit is zero
        logic cnt_zero;   // top buffered digit is the least significant one
        logic overflow;   // value had digits above the buffer
    } u2d_status_t;

endpackage

// ===== rtl/u2d_datapath.sv =====
// Datapath: shift-and-add-3 binary to BCD converter and digit shift-out buffer.
// Depends on u2d_pkg.
module u2d_datapath
    import u2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  u2d_cmd_t           cmd,
    input  logic [VALUE_W-1:0] value,
    output u2d_status_t        status,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    localparam int DEPTH     = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
    localparam int BCD_W     = DEPTH * DIGIT_W;
    localparam int CNT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   top_digit;

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        if (cmd.load) begin
            bin_next     = value;
            bcd_next     = '0;
            ovf_next     = 1'b0;
            cnt_next     = CNT_W'(DEPTH - 1);
            bit_cnt_next = '0;
        end else if (cmd.step) begin
            // bits leaving the top digit mean the value outgrows the buffer
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            ovf_next     = ovf_reg | bcd_adj[BCD_W-1];
            bin_next     = bin_reg << 1;
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end else if (cmd.advance) begin
            bcd_next = bcd_reg << DIGIT_W;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        ovf_reg     <= ovf_next;
        cnt_reg     <= cnt_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    assign status.conv_done = (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1));
    assign status.top_zero  = (top_digit == '0);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.overflow  = ovf_reg;

    assign digit_char = CHAR_W'(ASCII_ZERO) + CHAR_W'(top_digit);
    assign last_digit = (cnt_reg == '0);

endmodule

// ===== rtl/u2d_ctrl.sv =====
// Controller: sequences load, conversion, leading-zero scan and digit output.
// Depends on u2d_pkg.
module u2d_ctrl
    import u2d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  u2d_status_t status,
    output u2d_cmd_t    cmd
);

    u2d_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (status.conv_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // skip leading zeros, but never the ones under a dropped digit
                if (status.overflow || !status.top_zero || status.cnt_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.cnt_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/unsigned_to_decimal_ascii.sv =====
// Unsigned binary to decimal ASCII converter, top level.
// Depends on u2d_pkg, u2d_ctrl, u2d_datapath and unsigned_to_decimal_ascii_assert.svh.
//
// Each word on the s_ channel is a 32-bit unsigned number; the block answers
// with its decimal digits as ASCII codes on the m_ channel, most significant
// digit first, one word per digit, leading zeros suppressed (zero gives a
// single '0'). m_last_digit marks the least significant digit, which ends the
// run. With MAX_DIGITS below 10 only the MAX_DIGITS low digits are kept: a
// number that outgrows the buffer prints all of them, zeros included, and its
// higher digits are dropped. One number is handled at a time: s_ready is high
// only while the block is idle. With m_ready held high each item runs the
// same sequence whatever its value: one load, 32 shift-and-add-3 steps (one
// input bit each), one step at the start of the scan, then one step per
// buffered digit either to skip a leading zero or to send a digit. The scan
// and the digit output shift the same BCD register, so a stalled m_ready
// simply holds the current digit.
// Reset is synchronous and active low and clears only the controller state.
`include "unsigned_to_decimal_ascii_assert.svh"

module unsigned_to_decimal_ascii
    import u2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // number in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    // digits out
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_digit_char,
    output logic               m_last_digit
);

    u2d_cmd_t    cmd;
    u2d_status_t status;

    // Controller: idle, convert, skip leading zeros, send digits
    u2d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: binary shift register, BCD digit buffer, digit counter
    u2d_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .value      (s_value),
        .status     (status),
        .digit_char (m_digit_char),
        .last_digit (m_last_digit)
    );

    // Never take a number while a digit is on offer
    `U2D_ASSERT_SAME(a_ready_excl, s_ready, !m_valid, "s_ready and m_valid both high")

    // Every digit shown is an ASCII decimal digit
    `U2D_ASSERT_SAME(a_digit_range, m_valid, (m_digit_char >= 6'd48) && (m_digit_char <= 6'd57), "digit out of range")

    // Accepting a number starts conversion: nothing ready, nothing shown
    `U2D_ASSERT_NEXT(a_load_busy, s_valid && s_ready, !s_ready && !m_valid, "not busy after load")

    // The last digit of a run returns the block to idle
    `U2D_ASSERT_NEXT(a_last_idle, m_valid && m_ready && m_last_digit, s_ready && !m_valid, "not idle after last digit")

endmodule

// ===== tb/unsigned_to_decimal_ascii_tb.sv =====
// Testbench for unsigned_to_decimal_ascii: checks every ASCII digit word against typed digits or a predictor.
// Depends on u2d_pkg and the unsigned_to_decimal_ascii RTL; self-contained otherwise.
`timescale 1ns / 100ps

module unsigned_to_decimal_ascii_tb;
    import u2d_pkg::*;

    // Buffer depth handed to the block. Below HW_DIGITS the high digits get dropped.
    parameter int MAX_DIGITS = MAX_DIGITS_DEF;

    localparam int N_ROWS         = 24;
    localparam int RANDOM_ITEMS   = 200 - N_ROWS;
    localparam int DRAIN_CYCLES   = 80;    // wait after the final drain for stray words
    localparam int WATCHDOG_LIMIT = 3000;  // handshake-free cycles before the bench gives up

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_word_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_digit_char;
    logic               m_last_digit;

    digit_word_t digits_due[$];  // ASCII words still owed by the block, oldest first
    int          fail_count  = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    bit          steady      = 1'b0;  // set for stretches where neither side idles

    // Directed numbers. A text entry holds the digits that the block must print;
    // an empty entry leaves the number to the predictor.
    logic [VALUE_W-1:0] row_value [N_ROWS] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000,
        32'd65535, 32'd65536, 32'd999999999, 32'd1000000000, 32'd1234567890,
        32'd2147483647, 32'd2147483648, 32'd3000000001, 32'd4000000000,
        32'd4294967294, 32'd4294967295, 32'hA5A5A5A5, 32'h5A5A5A5A,
        32'h0000FFFF, 32'hFFFF0000, 32'd7
    };
    string row_text [N_ROWS] = '{
        "0", "1", "9", "10", "99", "100", "101", "1000",
        "65535", "65536", "999999999", "1000000000", "1234567890",
        "2147483647", "2147483648", "3000000001", "4000000000",
        "4294967294", "4294967295", "", "",
        "", "", "7"
    };

    unsigned_to_decimal_ascii #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit_char(m_digit_char),
        .m_last_digit(m_last_digit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Queue the ASCII digits of one number: peel off decimal digits from the
    // low end until the number runs out or the buffer is full, then emit them
    // most significant first. Zero still yields one '0'.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] dec [HW_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 depth;
        int                 count;
        depth = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
        if (depth < 1)
            depth = 1;
        rest  = value;
        count = 0;
        if (rest == '0) begin
            dec[0] = '0;
            count  = 1;
        end else begin
            while (rest != '0 && count < depth) begin
                dec[count] = DIGIT_W'(rest % 10);
                rest       = rest / 10;
                count++;
            end
        end
        for (int k = count - 1; k >= 0; k--)
            digits_due.push_back('{code: CHAR_W'(ASCII_ZERO + dec[k]), last: (k == 0)});
    endfunction

    // Spread values over every digit count so short runs are as common as long
    // ones; full-range words keep every input bit toggling.
    function automatic logic [VALUE_W-1:0] random_value();
        int                 pick;
        int                 ndig;
        logic [VALUE_W-1:0] cap;
        pick = $urandom_range(0, 9);
        ndig = $urandom_range(1, 9);
        cap  = 1;
        for (int i = 0; i < ndig; i++)
            cap = cap * 10;
        if (pick < 4)
            return $urandom;
        if (pick == 4)
            return $urandom_range(0, 9);
        if (pick == 5)
            return $urandom_range(0, 1) ? cap : cap - 1;
        return $urandom_range(0, cap - 1);
    endfunction

    // Offer one number and hold it until the block takes it, then record the
    // digits it owes. Valid stays high on return; the caller drops it for a gap or a drain.
    task automatic offer_number(input logic [VALUE_W-1:0] value, input string text);
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // Typed digits only hold for a buffer deep enough for every 32-bit number.
        if (text.len() == 0 || MAX_DIGITS < HW_DIGITS) begin
            predict_digits(value);
        end else begin
            for (int i = 0; i < text.len(); i++)
                digits_due.push_back('{code: CHAR_W'(text.getc(i)), last: (i == text.len() - 1)});
        end
    endtask

    // Drop valid for a random gap; scramble the payload while it is idle.
    task automatic sender_gap();
        int n;
        n = steady ? 0 : gap_cycles();
        if (n > 0) begin
            s_valid <= 1'b0;
            s_value <= $urandom;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Drop valid and hold off new numbers until every owed digit has come out.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (digits_due.size() != 0)
            @(posedge aclk);
    endtask

    // Digit receiver: check each accepted word against the oldest expectation,
    // then decide ready for the next cycle.
    always @(posedge aclk) begin
        digit_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digits_due.size() == 0) begin
                $error("unexpected digit word: digit_char %0d, last_digit %0d",
                       m_digit_char, m_last_digit);
                fail_count++;
            end else begin
                want = digits_due.pop_front();
                if (m_digit_char !== want.code) begin
                    $error("digit_char: expected %0d, got %0d", want.code, m_digit_char);
                    fail_count++;
                end
                if (m_last_digit !== want.last) begin
                    $error("last_digit: expected %0d, got %0d", want.last, m_last_digit);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!steady)
                stall_left = gap_cycles();
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("unsigned_to_decimal_ascii test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, digit-count boundaries, zero.
        for (int r = 0; r < N_ROWS; r++) begin
            offer_number(row_value[r], row_text[r]);
            sender_gap();
        end
        wait_for_drain();

        // Random part, with a stretch of back-to-back traffic and one full drain.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 60 && i < 90);
            if (i == 120)
                wait_for_drain();
            offer_number(random_value(), "");
            sender_gap();
        end
        steady  = 1'b0;
        s_valid <= 1'b0;

        // Let the last run finish, then give stray words time to show up.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && digits_due.size() == 0) begin
            $display("unsigned_to_decimal_ascii test passed");
        end else begin
            $display("unsigned_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/u2d_pkg.sv
rtl/u2d_datapath.sv
rtl/u2d_ctrl.sv
rtl/unsigned_to_decimal_ascii.sv
tb/unsigned_to_decimal_ascii_tb.sv
